// File: design/gprb_pkg.sv
// gprb_pkg: shared widths, angle constants and the arctangent table for the
// range and bearing pipeline. No dependencies.
package gprb_pkg;

   // default number of cordic iterations
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_TAB_LEN      = 24;

   // cordic datapath widths
   localparam int CIN_W    = 34;   // cordic operand input width
   localparam int CW       = 44;   // cordic x/y working width
   localparam int ANG_W    = 34;   // angle accumulator, q3.29
   localparam int NORM_EXP = 40;   // normalize until magnitude reaches 2^40

   // sqrt pipeline depth: abs, partial products, squares, sum, 33 digits, round
   localparam int SQRT_DIGITS = 33;
   localparam int SQRT_LAT    = SQRT_DIGITS + 5;

   // angle constants, q3.29
   localparam logic signed [ANG_W-1:0] HALF_PI_Q29 = 34'sd843314857;
   localparam logic signed [ANG_W:0]   PI_Q29      = 35'sd1686629713;
   localparam logic signed [ANG_W:0]   TWO_PI_Q29  = 35'sd3373259426;

   // one cordic stage word
   typedef struct packed {
      logic signed [CW-1:0]    x;
      logic signed [CW-1:0]    y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } cordic_stage_type;

   // one square root digit stage word
   typedef struct packed {
      logic [35:0] rem;
      logic [33:0] root;
      logic [65:0] rad;
   } sqrt_stage_type;

   // atan(2^-i) in q3.29
   function automatic logic signed [ANG_W-1:0] atan_q29(input logic [4:0] idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         5'd0:    val = 34'sd421657428;
         5'd1:    val = 34'sd248918915;
         5'd2:    val = 34'sd131521918;
         5'd3:    val = 34'sd66762579;
         5'd4:    val = 34'sd33510843;
         5'd5:    val = 34'sd16771758;
         5'd6:    val = 34'sd8387925;
         5'd7:    val = 34'sd4194219;
         5'd8:    val = 34'sd2097141;
         5'd9:    val = 34'sd1048575;
         5'd10:   val = 34'sd524288;
         5'd11:   val = 34'sd262144;
         5'd12:   val = 34'sd131072;
         5'd13:   val = 34'sd65536;
         5'd14:   val = 34'sd32768;
         5'd15:   val = 34'sd16384;
         5'd16:   val = 34'sd8192;
         5'd17:   val = 34'sd4096;
         5'd18:   val = 34'sd2048;
         5'd19:   val = 34'sd1024;
         5'd20:   val = 34'sd512;
         5'd21:   val = 34'sd256;
         5'd22:   val = 34'sd128;
         5'd23:   val = 34'sd64;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: design/gprb_cordic.sv
// gprb_cordic: pipelined cordic vectoring unit, angle of (x, y) in q3.29.
// Normalize in six shift stages, pre-rotate, then one stage per iteration.
// Depends on gprb_pkg.
module gprb_cordic
   import gprb_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [CIN_W-1:0] in_x,
   input  logic signed [CIN_W-1:0] in_y,
   output logic signed [ANG_W-1:0] out_angle
);

   cordic_stage_type norm_src [6];
   cordic_stage_type norm_in  [6];
   cordic_stage_type norm_ff  [6];
   cordic_stage_type pre_in;
   cordic_stage_type pre_ff;
   cordic_stage_type it_src [STAGES];
   cordic_stage_type it_in  [STAGES];
   cordic_stage_type it_ff  [STAGES];

   // first stage takes the operands straight from the ports
   assign norm_src[0] = '{x: CW'(in_x), y: CW'(in_y), z: '0,
                          zero: (in_x == '0) && (in_y == '0)};

   // binary normalize: shift by 32, 16, 8, 4, 2, 1 while below the limit
   for (genvar j = 0; j < 6; j++) begin : g_norm
      localparam int SH = 32 >> j;
      logic [CW-1:0] ax;
      logic [CW-1:0] ay;
      if (j > 0) begin : g_src
         assign norm_src[j] = norm_ff[j-1];
      end
      always_comb begin
         ax = norm_src[j].x[CW-1] ? CW'(-norm_src[j].x) : CW'(norm_src[j].x);
         ay = norm_src[j].y[CW-1] ? CW'(-norm_src[j].y) : CW'(norm_src[j].y);
         norm_in[j] = norm_src[j];
         if (((ax >> (NORM_EXP - SH)) == '0) && ((ay >> (NORM_EXP - SH)) == '0)) begin
            norm_in[j].x = norm_src[j].x <<< SH;
            norm_in[j].y = norm_src[j].y <<< SH;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            norm_ff[j] <= norm_in[j];
         end
      end
   end

   // last doubling and left half-plane pre-rotation
   always_comb begin
      logic signed [CW-1:0] x2;
      logic signed [CW-1:0] y2;
      x2 = norm_ff[5].x <<< 1;
      y2 = norm_ff[5].y <<< 1;
      pre_in = '{x: x2, y: y2, z: '0, zero: norm_ff[5].zero};
      if (x2[CW-1]) begin
         if (!y2[CW-1]) begin
            pre_in.x = y2;
            pre_in.y = -x2;
            pre_in.z = HALF_PI_Q29;
         end else begin
            pre_in.x = -y2;
            pre_in.y = x2;
            pre_in.z = -HALF_PI_Q29;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_ff <= pre_in;
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      if (i == 0) begin : g_first
         assign it_src[i] = pre_ff;
      end else begin : g_next
         assign it_src[i] = it_ff[i-1];
      end
      always_comb begin
         it_in[i] = it_src[i];
         if (!it_src[i].y[CW-1]) begin
            it_in[i].x = it_src[i].x + (it_src[i].y >>> i);
            it_in[i].y = it_src[i].y - (it_src[i].x >>> i);
            it_in[i].z = it_src[i].z + atan_q29(5'(i));
         end else begin
            it_in[i].x = it_src[i].x - (it_src[i].y >>> i);
            it_in[i].y = it_src[i].y + (it_src[i].x >>> i);
            it_in[i].z = it_src[i].z - atan_q29(5'(i));
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            it_ff[i] <= it_in[i];
         end
      end
   end

   // zero vector gives angle zero
   assign out_angle = it_ff[STAGES-1].zero ? '0 : it_ff[STAGES-1].z;

endmodule

// File: design/gprb_sqrt.sv
// gprb_sqrt: pipelined rounded euclidean length of a 33-bit signed pair.
// Squares from partial products, then one root digit per stage. Depends on gprb_pkg.
module gprb_sqrt
   import gprb_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [32:0] in_dx,
   input  logic signed [32:0] in_dy,
   output logic        [32:0] out_root
);

   logic [32:0] ax_ff, ay_ff;
   logic [33:0] xhh_ff, yhh_ff;
   logic [32:0] xhl_ff, yhl_ff;
   logic [31:0] xll_ff, yll_ff;
   logic [65:0] sqx_ff, sqy_ff;
   logic [65:0] sum_ff;
   sqrt_stage_type dg_src [SQRT_DIGITS];
   sqrt_stage_type dg_in  [SQRT_DIGITS];
   sqrt_stage_type dg_ff  [SQRT_DIGITS];
   logic [32:0] root_ff;

   // magnitudes, partial products, squares and their sum
   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff  <= in_dx[32] ? 33'(-in_dx) : 33'(in_dx);
         ay_ff  <= in_dy[32] ? 33'(-in_dy) : 33'(in_dy);
         xhh_ff <= 34'(ax_ff[32:16]) * 34'(ax_ff[32:16]);
         xhl_ff <= 33'(ax_ff[32:16]) * 33'(ax_ff[15:0]);
         xll_ff <= ax_ff[15:0] * ax_ff[15:0];
         yhh_ff <= 34'(ay_ff[32:16]) * 34'(ay_ff[32:16]);
         yhl_ff <= 33'(ay_ff[32:16]) * 33'(ay_ff[15:0]);
         yll_ff <= ay_ff[15:0] * ay_ff[15:0];
         sqx_ff <= (66'(xhh_ff) << 32) + (66'(xhl_ff) << 17) + 66'(xll_ff);
         sqy_ff <= (66'(yhh_ff) << 32) + (66'(yhl_ff) << 17) + 66'(yll_ff);
         sum_ff <= sqx_ff + sqy_ff;
      end
   end

   // restoring square root, one bit pair per stage from the top
   for (genvar s = 0; s < SQRT_DIGITS; s++) begin : g_digit
      localparam int K = SQRT_DIGITS - 1 - s;
      logic [35:0] rem_t;
      logic [35:0] trial;
      if (s == 0) begin : g_first
         assign dg_src[s] = '{rem: '0, root: '0, rad: sum_ff};
      end else begin : g_next
         assign dg_src[s] = dg_ff[s-1];
      end
      always_comb begin
         rem_t = {dg_src[s].rem[33:0], dg_src[s].rad[2*K+1 -: 2]};
         trial = {dg_src[s].root, 2'b01};
         dg_in[s] = dg_src[s];
         if (rem_t >= trial) begin
            dg_in[s].rem  = rem_t - trial;
            dg_in[s].root = {dg_src[s].root[32:0], 1'b1};
         end else begin
            dg_in[s].rem  = rem_t;
            dg_in[s].root = {dg_src[s].root[32:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dg_ff[s] <= dg_in[s];
         end
      end
   end

   // round to nearest
   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= dg_ff[SQRT_DIGITS-1].root[32:0]
                  + 33'(36'(dg_ff[SQRT_DIGITS-1].rem) > 36'(dg_ff[SQRT_DIGITS-1].root));
      end
   end

   assign out_root = root_ff;

endmodule

// File: design/global_point_to_range_bearing_top.sv
// global_point_to_range_bearing_top: target range and bearing in the observer frame.
// The square root digit pipeline sets the latency; the bearing path is
// delayed to match. Throughput is one word per cycle; the whole pipeline holds
// while a finished word waits on rsp_ready. Synchronous reset clears the valid
// bits only; no clearing pass. Depends on gprb_pkg, gprb_cordic, gprb_sqrt.
module global_point_to_range_bearing_top
   import gprb_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_own_x,
   input  logic signed [31:0] req_own_y,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [32:0] rsp_target_range,
   output logic signed [15:0] rsp_target_bearing
);

   localparam int LAT = SQRT_LAT + 1;
   localparam int DLY = LAT - (CORDIC_STAGES + 13);

   logic en;
   logic [LAT:1] vld_ff;
   logic signed [32:0] dx_ff, dy_ff, dx2_ff, dy2_ff;
   logic signed [31:0] pwz_ff, pxy_ff, pyy_ff, pzz_ff;
   logic signed [CIN_W-1:0] num_ff, den_ff;
   logic signed [ANG_W-1:0] theta, yaw;
   logic signed [ANG_W:0] diff_ff, wr1_ff, wr2_ff;
   logic signed [ANG_W:0] wr1_in, wr2_in;
   logic signed [35:0] rnd;
   logic signed [15:0] brg_ff [DLY+1];

   // pipeline advances unless the output word is stalled
   assign en        = !vld_ff[LAT] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-1:1], req_valid};
      end
   end

   // differences and quaternion products, then yaw numerator and denominator
   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= 33'(req_target_x) - 33'(req_own_x);
         dy_ff  <= 33'(req_target_y) - 33'(req_own_y);
         pwz_ff <= req_quat_w * req_quat_z;
         pxy_ff <= req_quat_x * req_quat_y;
         pyy_ff <= req_quat_y * req_quat_y;
         pzz_ff <= req_quat_z * req_quat_z;
         dx2_ff <= dx_ff;
         dy2_ff <= dy_ff;
         num_ff <= (CIN_W'(pwz_ff) + CIN_W'(pxy_ff)) <<< 1;
         den_ff <= (CIN_W'(1) <<< 28) - ((CIN_W'(pyy_ff) + CIN_W'(pzz_ff)) <<< 1);
      end
   end

   gprb_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .in_dx    (dx_ff),
      .in_dy    (dy_ff),
      .out_root (rsp_target_range)
   );

   gprb_cordic #(.STAGES(CORDIC_STAGES)) u_theta (
      .clock     (clock),
      .en        (en),
      .in_x      (CIN_W'(dx2_ff)),
      .in_y      (CIN_W'(dy2_ff)),
      .out_angle (theta)
   );

   gprb_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
      .clock     (clock),
      .en        (en),
      .in_x      (den_ff),
      .in_y      (num_ff),
      .out_angle (yaw)
   );

   // wrap into (-pi, pi], applied twice
   always_comb begin
      wr1_in = diff_ff;
      if (diff_ff > PI_Q29) begin
         wr1_in = diff_ff - TWO_PI_Q29;
      end else if (diff_ff <= -PI_Q29) begin
         wr1_in = diff_ff + TWO_PI_Q29;
      end
      wr2_in = wr1_ff;
      if (wr1_ff > PI_Q29) begin
         wr2_in = wr1_ff - TWO_PI_Q29;
      end else if (wr1_ff <= -PI_Q29) begin
         wr2_in = wr1_ff + TWO_PI_Q29;
      end
   end

   // round q3.29 to q3.13
   assign rnd = (36'(wr2_ff) + 36'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff   <= (ANG_W+1)'(theta) - (ANG_W+1)'(yaw);
         wr1_ff    <= wr1_in;
         wr2_ff    <= wr2_in;
         brg_ff[0] <= rnd[15:0];
      end
   end

   // align bearing with the range path
   for (genvar d = 1; d <= DLY; d++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en) begin
            brg_ff[d] <= brg_ff[d-1];
         end
      end
   end

   assign rsp_target_bearing = brg_ff[DLY];

endmodule
